[hdl/tpag_pkg.sv]
// ----------------------------------------------------------------------------
// tpag_pkg
// Shared types, constants and helpers of the tensor permute address generator.
// ----------------------------------------------------------------------------
package tpag_pkg;

    localparam int AXIS_SLOTS  = 6;
    localparam int SLOT_BITS   = $clog2(AXIS_SLOTS);
    localparam int FIELD_BITS  = 3;
    localparam int AXIS_CODES  = 1 << FIELD_BITS;
    localparam int ORDER_BITS  = AXIS_SLOTS * FIELD_BITS;
    localparam int COUNT_BITS  = 3;
    localparam int DIM_BITS    = 16;
    localparam int OUT_BITS    = 32;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;

    localparam int MAX_AXES_DEFAULT    = 6;
    localparam int OFFSET_BITS_DEFAULT = 32;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_AXIS_COUNT = 3'd0;
    localparam reg_idx_t REG_AXIS_ORDER = 3'd1;
    localparam reg_idx_t REG_OUT_DIM_0  = 3'd2;
    localparam reg_idx_t REG_OUT_DIM_1  = 3'd3;
    localparam reg_idx_t REG_OUT_DIM_2  = 3'd4;
    localparam reg_idx_t REG_OUT_DIM_3  = 3'd5;
    localparam reg_idx_t REG_OUT_DIM_4  = 3'd6;
    localparam reg_idx_t REG_OUT_DIM_5  = 3'd7;

    typedef logic [DIM_BITS-1:0]   dim_t;
    typedef logic [FIELD_BITS-1:0] field_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]     axis_count;
        logic [ORDER_BITS-1:0]     axis_order;
        dim_t [AXIS_SLOTS-1:0]     out_dim;
    } cfg_t;

    // broadcast from the stride sequencer to every cell
    typedef struct packed {
        logic   step;
        logic   first;
        dim_t   dim;
        field_t field;
    } derive_ctl_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] source_offset;
        logic [OUT_BITS-1:0] dest_offset;
        logic                last;
        logic                bad_config;
    } pair_t;

    function automatic field_t order_field(logic [ORDER_BITS-1:0] order, int j);
        return order[FIELD_BITS*j +: FIELD_BITS];
    endfunction

endpackage

[hdl/tpag_if.sv]
// ----------------------------------------------------------------------------
// tpag_if
// Valid/ready channels for step requests and address pair results.
// ----------------------------------------------------------------------------
interface tpag_step_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface tpag_pair_if import tpag_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] source_offset;
    logic [OUT_BITS-1:0] dest_offset;
    logic                last;
    logic                bad_config;

    modport source (output valid, output source_offset, output dest_offset, output last,
                    output bad_config, input ready);
    modport sink (input valid, input source_offset, input dest_offset, input last,
                  input bad_config, output ready);
endinterface

[hdl/tpag_apb_regs.sv]
// ----------------------------------------------------------------------------
// tpag_apb_regs
// APB configuration registers: axis count, axis order and six output sizes.
// ----------------------------------------------------------------------------
module tpag_apb_regs import tpag_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg,
    output logic                     cfg_wr
);

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = paddr[APB_ADDR_BITS-1:2];
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_count <= COUNT_BITS'(1);
            cfg_reg.axis_order <= '0;
            for (int j = 0; j < AXIS_SLOTS; j++)
            begin
                cfg_reg.out_dim[j] <= DIM_BITS'(1);
            end
        end
        else if (cfg_wr)
        begin
            unique case (idx)
                REG_AXIS_COUNT: cfg_reg.axis_count <= pwdata[COUNT_BITS-1:0];
                REG_AXIS_ORDER: cfg_reg.axis_order <= pwdata[ORDER_BITS-1:0];
                REG_OUT_DIM_0:  cfg_reg.out_dim[0] <= pwdata[DIM_BITS-1:0];
                REG_OUT_DIM_1:  cfg_reg.out_dim[1] <= pwdata[DIM_BITS-1:0];
                REG_OUT_DIM_2:  cfg_reg.out_dim[2] <= pwdata[DIM_BITS-1:0];
                REG_OUT_DIM_3:  cfg_reg.out_dim[3] <= pwdata[DIM_BITS-1:0];
                REG_OUT_DIM_4:  cfg_reg.out_dim[4] <= pwdata[DIM_BITS-1:0];
                REG_OUT_DIM_5:  cfg_reg.out_dim[5] <= pwdata[DIM_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_AXIS_COUNT: prdata = APB_DATA_BITS'(cfg_reg.axis_count);
            REG_AXIS_ORDER: prdata = APB_DATA_BITS'(cfg_reg.axis_order);
            REG_OUT_DIM_0:  prdata = APB_DATA_BITS'(cfg_reg.out_dim[0]);
            REG_OUT_DIM_1:  prdata = APB_DATA_BITS'(cfg_reg.out_dim[1]);
            REG_OUT_DIM_2:  prdata = APB_DATA_BITS'(cfg_reg.out_dim[2]);
            REG_OUT_DIM_3:  prdata = APB_DATA_BITS'(cfg_reg.out_dim[3]);
            REG_OUT_DIM_4:  prdata = APB_DATA_BITS'(cfg_reg.out_dim[4]);
            REG_OUT_DIM_5:  prdata = APB_DATA_BITS'(cfg_reg.out_dim[5]);
        endcase
    end

endmodule

[hdl/tpag_deriver.sv]
// ----------------------------------------------------------------------------
// tpag_deriver
// Stride sequencer: steps over the output axes, checks the configuration
// and counts the elements.
// ----------------------------------------------------------------------------
module tpag_deriver import tpag_pkg::*;
#(
    parameter int NUM_CELLS   = MAX_AXES_DEFAULT,
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   start,
    output derive_ctl_t            der,
    output logic                   busy,
    output logic                   cfg_ok,
    output logic [OFFSET_BITS-1:0] elem_count
);

    localparam int KW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    logic [KW-1:0]             k_reg, k_next;
    logic                      busy_reg, busy_next;
    logic                      ok_reg, ok_next;
    logic                      ovf_reg, ovf_next;
    logic [OFFSET_BITS-1:0]    count_reg, count_next;

    logic [SLOT_BITS-1:0]          slot;
    logic                          active;
    logic                          first;
    logic [OFFSET_BITS-1:0]        count_src;
    logic                          ovf_src;
    logic [OFFSET_BITS+DIM_BITS-1:0] prod;
    logic                          step_ovf;
    logic                          n_ok, perm_ok, dims_ok;

    assign slot   = SLOT_BITS'(k_reg);
    assign active = (COUNT_BITS'(k_reg) < cfg.axis_count);
    assign first  = (k_reg == '0);

    assign der.step  = busy_reg & active;
    assign der.first = first;
    assign der.dim   = cfg.out_dim[slot];
    assign der.field = order_field(cfg.axis_order, int'(slot));

    assign count_src = first ? OFFSET_BITS'(1) : count_reg;
    assign ovf_src   = first ? 1'b0 : ovf_reg;
    assign prod      = count_src * der.dim;
    assign step_ovf  = |prod[OFFSET_BITS+DIM_BITS-1:OFFSET_BITS];

    // used order fields must name each used axis exactly once; used sizes must be nonzero
    always_comb
    begin
        logic [AXIS_CODES-1:0] seen;
        logic [AXIS_CODES-1:0] full;
        logic                  in_range;
        field_t                f;
        seen     = '0;
        full     = '0;
        in_range = 1'b1;
        dims_ok  = 1'b1;
        f        = '0;
        for (int i = 0; i < AXIS_CODES; i++)
        begin
            full[i] = (COUNT_BITS'(i) < cfg.axis_count);
        end
        for (int j = 0; j < NUM_CELLS; j++)
        begin
            if (COUNT_BITS'(j) < cfg.axis_count)
            begin
                f = order_field(cfg.axis_order, j);
                if (COUNT_BITS'(f) >= cfg.axis_count)
                begin
                    in_range = 1'b0;
                end
                seen[f] = 1'b1;
                if (cfg.out_dim[j] == '0)
                begin
                    dims_ok = 1'b0;
                end
            end
        end
        perm_ok = in_range && (seen == full);
        n_ok    = (cfg.axis_count != '0) && (int'(cfg.axis_count) <= NUM_CELLS);
    end

    always_comb
    begin
        k_next     = k_reg;
        busy_next  = busy_reg;
        ok_next    = ok_reg;
        ovf_next   = ovf_reg;
        count_next = count_reg;
        if (start)
        begin
            k_next    = '0;
            busy_next = 1'b1;
            ok_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            count_next = active ? prod[OFFSET_BITS-1:0] : count_src;
            ovf_next   = active ? (ovf_src | step_ovf) : ovf_src;
            k_next     = KW'(k_reg + 1'b1);
            if (int'(k_reg) == NUM_CELLS - 1)
            begin
                k_next    = '0;
                busy_next = 1'b0;
                ok_next   = n_ok & perm_ok & dims_ok & ~ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            busy_reg  <= 1'b1;
            ok_reg    <= 1'b0;
            ovf_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            k_reg     <= k_next;
            busy_reg  <= busy_next;
            ok_reg    <= ok_next;
            ovf_reg   <= ovf_next;
            count_reg <= count_next;
        end
    end

    assign busy       = busy_reg;
    assign cfg_ok     = ok_reg;
    assign elem_count = count_reg;

endmodule

[hdl/tpag_cell.sv]
// ----------------------------------------------------------------------------
// tpag_cell
// One axis level: coordinate counter, level base and source stride.
// ----------------------------------------------------------------------------
module tpag_cell import tpag_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   enabled,
    input  dim_t                   dim,
    input  field_t                 field,
    input  derive_ctl_t            der,
    input  logic                   clear,
    input  logic                   advance,
    input  logic                   restart,
    input  logic                   carry_in,
    output logic                   carry_out,
    input  logic [OFFSET_BITS-1:0] base_in,
    output logic [OFFSET_BITS-1:0] base_out,
    output logic [OFFSET_BITS-1:0] base_now
);

    dim_t                   coord_reg, coord_next, coord_eff;
    logic [OFFSET_BITS-1:0] base_reg, base_next, base_eff;
    logic [OFFSET_BITS-1:0] stride_reg, stride_next, stride_src;
    logic [OFFSET_BITS+DIM_BITS-1:0] stride_prod;
    logic                   wrap, bump, wrap_back;

    assign coord_eff = restart ? '0 : coord_reg;
    assign base_eff  = restart ? '0 : base_reg;

    // unused levels pass the carry straight through
    assign wrap      = ~enabled | (coord_eff == dim - DIM_BITS'(1));
    assign carry_out = carry_in & wrap;
    assign bump      = enabled & carry_in & ~wrap;
    assign wrap_back = enabled & carry_in & wrap;

    always_comb
    begin
        coord_next = coord_eff;
        base_next  = base_eff;
        if (bump)
        begin
            coord_next = dim_t'(coord_eff + 1'b1);
            base_next  = base_eff + stride_reg;
        end
        else if (wrap_back)
        begin
            coord_next = '0;
            base_next  = base_in;
        end
    end

    assign base_out = base_next;
    assign base_now = base_eff;

    // stride is the product of the sizes of all later input axes
    assign stride_src  = der.first ? OFFSET_BITS'(1) : stride_reg;
    assign stride_prod = stride_src * der.dim;

    always_comb
    begin
        stride_next = stride_reg;
        if (der.step)
        begin
            stride_next = (der.field > field) ? stride_prod[OFFSET_BITS-1:0] : stride_src;
        end
    end

    always_ff @(posedge clk)
    begin
        stride_reg <= stride_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_reg <= '0;
            base_reg  <= '0;
        end
        else if (clear)
        begin
            coord_reg <= '0;
            base_reg  <= '0;
        end
        else if (advance)
        begin
            coord_reg <= coord_next;
            base_reg  <= base_next;
        end
    end

endmodule

[hdl/tpag_out_queue.sv]
// ----------------------------------------------------------------------------
// tpag_out_queue
// Two-entry result queue between the walk and the pair channel.
// ----------------------------------------------------------------------------
module tpag_out_queue import tpag_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  pair_t push_data,
    output logic  can_push,
    output logic  out_valid,
    input  logic  out_ready,
    output pair_t out_data
);

    pair_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       pop;

    assign can_push  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

[hdl/tensor_permute_address_generator_top.sv]
// ----------------------------------------------------------------------------
// tensor_permute_address_generator_top
// Address pair generator for an N-axis tensor permute.
// ----------------------------------------------------------------------------
// Each step request yields one pair: dest_offset walks the output tensor in
// row-major order and source_offset is where that element sits in the input
// tensor. One request is taken every cycle while the sequencer is idle and
// the two-entry result queue has room; the coordinate carry ripples through
// the axis cells combinationally, and the queue lets requests keep flowing
// while a result waits on the pair channel. After reset and every register
// write the sequencer steps over the axes, one axis per cycle, and step.ready
// stays low until it is done. A write also returns the walk to element zero.
// ----------------------------------------------------------------------------
module tensor_permute_address_generator_top import tpag_pkg::*;
#(
    parameter int MAX_AXES    = MAX_AXES_DEFAULT,
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    tpag_step_if.sink                step,
    tpag_pair_if.source              pair,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int NUM_CELLS = (MAX_AXES < AXIS_SLOTS) ? MAX_AXES : AXIS_SLOTS;

    cfg_t                   cfg;
    logic                   cfg_wr;
    derive_ctl_t            der;
    logic                   busy;
    logic                   cfg_ok;
    logic [OFFSET_BITS-1:0] elem_count;
    logic                   can_push;
    logic                   accept;
    logic                   advance;
    pair_t                  res;
    pair_t                  q_data;

    logic                   carry [NUM_CELLS];
    logic [OFFSET_BITS-1:0] chain [NUM_CELLS];
    logic [OFFSET_BITS-1:0] base_now [NUM_CELLS];

    logic [OFFSET_BITS-1:0] pos_reg, pos_next, pos_eff;
    logic [OFFSET_BITS-1:0] src;

    tpag_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    tpag_deriver #(
        .NUM_CELLS   (NUM_CELLS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_deriver (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .start      (cfg_wr),
        .der        (der),
        .busy       (busy),
        .cfg_ok     (cfg_ok),
        .elem_count (elem_count)
    );

    assign step.ready = ~busy & can_push;
    assign accept     = step.valid & step.ready;
    assign advance    = accept & cfg_ok;

    for (genvar j = 0; j < NUM_CELLS; j++)
    begin : g_cell
        logic                   cin;
        logic [OFFSET_BITS-1:0] bin;

        // carries move outward from the innermost level, bases move inward
        if (j == NUM_CELLS - 1)
        begin : g_inner
            assign cin = 1'b1;
        end
        else
        begin : g_mid
            assign cin = carry[j+1];
        end

        if (j == 0)
        begin : g_outer
            assign bin = '0;
        end
        else
        begin : g_rest
            assign bin = chain[j-1];
        end

        tpag_cell #(
            .OFFSET_BITS (OFFSET_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .enabled   (COUNT_BITS'(j) < cfg.axis_count),
            .dim       (cfg.out_dim[j]),
            .field     (order_field(cfg.axis_order, j)),
            .der       (der),
            .clear     (cfg_wr),
            .advance   (advance),
            .restart   (step.restart),
            .carry_in  (cin),
            .carry_out (carry[j]),
            .base_in   (bin),
            .base_out  (chain[j]),
            .base_now  (base_now[j])
        );
    end

    assign pos_eff  = step.restart ? '0 : pos_reg;
    assign pos_next = carry[0] ? '0 : OFFSET_BITS'(pos_eff + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cfg_wr)
        begin
            pos_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
        end
    end

    // the innermost used level holds the source offset
    always_comb
    begin
        src = '0;
        for (int j = 0; j < NUM_CELLS; j++)
        begin
            if (COUNT_BITS'(j) == COUNT_BITS'(cfg.axis_count - 1'b1))
            begin
                src = base_now[j];
            end
        end
    end

    always_comb
    begin
        res = '0;
        if (!cfg_ok)
        begin
            res.bad_config = 1'b1;
        end
        else
        begin
            res.source_offset = OUT_BITS'(src);
            res.dest_offset   = OUT_BITS'(pos_eff);
            res.last          = ({1'b0, pos_eff} + 1'b1) == {1'b0, elem_count};
        end
    end

    tpag_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (pair.valid),
        .out_ready (pair.ready),
        .out_data  (q_data)
    );

    assign pair.source_offset = q_data.source_offset;
    assign pair.dest_offset   = q_data.dest_offset;
    assign pair.last          = q_data.last;
    assign pair.bad_config    = q_data.bad_config;

endmodule

[hdl/tpag_checker.sv]
// ----------------------------------------------------------------------------
// tpag_checker
// Port-level checks of the tensor permute address generator.
// ----------------------------------------------------------------------------
module tpag_checker import tpag_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                step_ready,
    input logic                pair_valid,
    input logic                pair_ready,
    input logic [OUT_BITS-1:0] source_offset,
    input logic [OUT_BITS-1:0] dest_offset,
    input logic                last,
    input logic                bad_config,
    input logic                psel,
    input logic                penable,
    input logic                pwrite
);

    // a flagged configuration never produces addresses
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && bad_config |-> source_offset == '0 && dest_offset == '0 && !last)
        else $error("bad_config result carries nonzero fields");

    // strides are rebuilt after a write, so no request is taken right away
    a_wr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |=> !step_ready)
        else $error("step request taken right after a register write");

    a_pair_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && !pair_ready |=>
            pair_valid && $stable({source_offset, dest_offset, last, bad_config}))
        else $error("stalled result changed");

endmodule

bind tensor_permute_address_generator_top tpag_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_ready    (step.ready),
    .pair_valid    (pair.valid),
    .pair_ready    (pair.ready),
    .source_offset (pair.source_offset),
    .dest_offset   (pair.dest_offset),
    .last          (pair.last),
    .bad_config    (pair.bad_config),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite)
);
